/* src/grid_line_of_sight_assert.svh */
// ---------------------------------------------------------------------------
// grid_line_of_sight assertion macros
// Concurrent checks on clk, quiet while arst_n is low; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef GRID_LINE_OF_SIGHT_ASSERT_SVH
`define GRID_LINE_OF_SIGHT_ASSERT_SVH

`ifndef SYNTHESIS
// implication checked at every clock edge outside reset
`define GLS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication outside reset
`define GLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GLS_ASSERT_IMP(lbl, ante, cons, msg)
`define GLS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* src/gls_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gls_pkg
// Shared types and codes of the grid line-of-sight block.
// ---------------------------------------------------------------------------
package gls_pkg;

	localparam int POS_W   = 8;
	localparam int ERR_W   = 9;
	localparam int COORD_W = 6;
	localparam int CFG_W   = 7;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic CFG_GRID_ROWS = 1'b0;
	localparam logic CFG_GRID_COLS = 1'b1;

	localparam logic [CFG_W-1:0] GRID_ROWS_RST = 7'd64;
	localparam logic [CFG_W-1:0] GRID_COLS_RST = 7'd64;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} walk_ctrl_t;

	typedef struct packed {
		logic signed [POS_W-1:0] row;
		logic signed [POS_W-1:0] col;
		logic                    last;
	} walk_stat_t;

endpackage

/* src/gls_grid_mem.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gls_grid_mem
// One-bit obstacle memory, one write and one registered read port.
// ---------------------------------------------------------------------------
module gls_grid_mem #(
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [2**AW];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* src/gls_walker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gls_walker
// Integer line stepper: one cell of the walk per step request.
// ---------------------------------------------------------------------------
module gls_walker import gls_pkg::*; (
	input  logic               clk,
	input  walk_ctrl_t         ctrl,
	input  logic [COORD_W-1:0] row_a,
	input  logic [COORD_W-1:0] col_a,
	input  logic [COORD_W-1:0] row_b,
	input  logic [COORD_W-1:0] col_b,
	output walk_stat_t         stat
);

	logic signed [POS_W-1:0] row_q, col_q;
	logic signed [ERR_W-1:0] err_q, left_q, dr2_q, dc2_q;
	logic                    row_up_q, col_up_q;

	logic [COORD_W-1:0]      dr, dc;
	logic                    row_up, col_up;
	logic signed [ERR_W-1:0] err_nxt, left_nxt;
	logic signed [POS_W-1:0] row_nxt, col_nxt, row_mv, col_mv;

	assign row_up = row_b > row_a;
	assign col_up = col_b > col_a;
	assign dr     = row_up ? row_b - row_a : row_a - row_b;
	assign dc     = col_up ? col_b - col_a : col_a - col_b;

	assign row_mv = row_up_q ? row_q + 8'sd1 : row_q - 8'sd1;
	assign col_mv = col_up_q ? col_q + 8'sd1 : col_q - 8'sd1;

	always_comb begin
		row_nxt  = row_q;
		col_nxt  = col_q;
		err_nxt  = err_q;
		left_nxt = left_q - 9'sd1;
		priority if (!err_q[ERR_W-1] && (err_q != '0)) begin
			row_nxt = row_mv;
			err_nxt = err_q - dc2_q;
		end else if (err_q[ERR_W-1]) begin
			col_nxt = col_mv;
			err_nxt = err_q + dr2_q;
		end else begin
			// zero error: diagonal, counts twice
			row_nxt  = row_mv;
			col_nxt  = col_mv;
			err_nxt  = err_q + dr2_q - dc2_q;
			left_nxt = left_q - 9'sd2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			row_q    <= POS_W'(row_a);
			col_q    <= POS_W'(col_a);
			row_up_q <= row_up;
			col_up_q <= col_up;
			dr2_q    <= ERR_W'({dr, 1'b0});
			dc2_q    <= ERR_W'({dc, 1'b0});
			err_q    <= ERR_W'(dr) - ERR_W'(dc);
			left_q   <= ERR_W'(dr) + ERR_W'(dc) + 9'sd1;
		end else if (ctrl.step) begin
			row_q  <= row_nxt;
			col_q  <= col_nxt;
			err_q  <= err_nxt;
			left_q <= left_nxt;
		end
	end

	assign stat.row  = row_q;
	assign stat.col  = col_q;
	assign stat.last = left_nxt[ERR_W-1] || (left_nxt == '0);

endmodule

/* src/grid_line_of_sight.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grid_line_of_sight
// Obstacle grid with cell writes and integer line-of-sight queries.
// ---------------------------------------------------------------------------
// Usage:
//   A request is taken at a clock edge with start high and busy low. req_type
//   selects a cell write (row_a, col_a, cell_obstacle) or a query from
//   (row_a, col_a) to (row_b, col_b). Every request gives one result: done is
//   high for one cycle with visible and coord_error valid in that cycle.
//   The receiver cannot stall; the result must be taken when done is high.
//   A write or a rejected query goes from DECODE straight to DONE. A query
//   walks one cell per cycle through the memory read port in WALK, then
//   passes DRAIN and DONE; cells = |dr| + |dc| + 1 less the diagonal steps,
//   at most 126 cells (no diagonal step when |dr| - |dc| is odd).
//   Only one request is in flight; busy stays high until done has been shown.
//   Reset: after arst_n rises the obstacle memory is cleared one cell per
//   cycle, all 2**(clog2(MAX_ROWS_P)+clog2(MAX_COLS_P)) cells (4096 by
//   default), with busy high. Config writes (cfg_wen, cfg_index, cfg_wdata)
//   are taken at any edge; grid_rows and grid_cols reset to 64.
// ---------------------------------------------------------------------------
`include "grid_line_of_sight_assert.svh"

module grid_line_of_sight import gls_pkg::*; #(
	parameter int MAX_ROWS_P = 64,
	parameter int MAX_COLS_P = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               req_type,
	input  logic [COORD_W-1:0] row_a,
	input  logic [COORD_W-1:0] col_a,
	input  logic [COORD_W-1:0] row_b,
	input  logic [COORD_W-1:0] col_b,
	input  logic               cell_obstacle,
	output logic               done,
	output logic               visible,
	output logic               coord_error,
	input  logic               cfg_wen,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_wdata
);

	localparam int RW = $clog2(MAX_ROWS_P);
	localparam int CW = $clog2(MAX_COLS_P);
	localparam int AW = RW + CW;

	state_t state_q, state_d;

	logic [CFG_W-1:0]   grid_rows_q, grid_cols_q;
	logic [CFG_W-1:0]   rows_lim, cols_lim;
	logic [AW-1:0]      clr_q;
	logic               req_type_q, obst_q;
	logic [COORD_W-1:0] row_a_q, col_a_q, row_b_q, col_b_q;
	logic               vis_q, cerr_q, blk_q, chk_s1, oob_s1;
	logic               a_ok, b_ok, dec_err, blk_nxt, oob;
	logic               accept;

	logic               mem_we, mem_wdata, mem_rdata;
	logic [AW-1:0]      mem_waddr, mem_raddr;
	logic [15:0]        wr_row_ext, wr_col_ext, rd_row_ext, rd_col_ext;

	walk_ctrl_t         wctrl;
	walk_stat_t         wstat;

	assign accept = start && !busy;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= GRID_ROWS_RST;
			grid_cols_q <= GRID_COLS_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_GRID_ROWS: grid_rows_q <= cfg_wdata;
				CFG_GRID_COLS: grid_cols_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign rows_lim = (int'(grid_rows_q) < MAX_ROWS_P) ? grid_rows_q : CFG_W'(MAX_ROWS_P);
	assign cols_lim = (int'(grid_cols_q) < MAX_COLS_P) ? grid_cols_q : CFG_W'(MAX_COLS_P);

	assign a_ok    = (CFG_W'(row_a_q) < rows_lim) && (CFG_W'(col_a_q) < cols_lim);
	assign b_ok    = (CFG_W'(row_b_q) < rows_lim) && (CFG_W'(col_b_q) < cols_lim);
	assign dec_err = (req_type_q == REQ_WRITE) ? !a_ok : !(a_ok && b_ok);

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= req_type;
			row_a_q    <= row_a;
			col_a_q    <= col_a;
			row_b_q    <= row_b;
			col_b_q    <= col_b;
			obst_q     <= cell_obstacle;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (clr_q == '1) state_d = ST_IDLE;
			ST_IDLE:   if (start) state_d = ST_DECODE;
			ST_DECODE: begin
				if ((req_type_q == REQ_QUERY) && !dec_err) state_d = ST_WALK;
				else state_d = ST_DONE;
			end
			ST_WALK:   if (wstat.last) state_d = ST_DRAIN;
			ST_DRAIN:  state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	assign wr_row_ext = 16'(row_a_q);
	assign wr_col_ext = 16'(col_a_q);
	assign rd_row_ext = 16'(wstat.row[POS_W-2:0]);
	assign rd_col_ext = 16'(wstat.col[POS_W-2:0]);

	// outputs of the sequencer
	always_comb begin
		busy       = 1'b1;
		mem_we     = 1'b0;
		mem_waddr  = clr_q;
		mem_wdata  = 1'b0;
		wctrl.load = 1'b0;
		wctrl.step = 1'b0;
		unique case (state_q)
			ST_CLEAR:  mem_we = 1'b1;
			ST_IDLE:   busy = 1'b0;
			ST_DECODE: begin
				mem_we     = (req_type_q == REQ_WRITE) && a_ok;
				mem_waddr  = {wr_row_ext[RW-1:0], wr_col_ext[CW-1:0]};
				mem_wdata  = obst_q;
				wctrl.load = 1'b1;
			end
			ST_WALK:   wctrl.step = 1'b1;
			ST_DRAIN:  ;
			ST_DONE:   ;
			default:   ;
		endcase
	end

	assign mem_raddr = {rd_row_ext[RW-1:0], rd_col_ext[CW-1:0]};

	// positions off the physical grid count as blocked
	assign oob = wstat.row[POS_W-1] || wstat.col[POS_W-1] ||
		(int'(wstat.row) >= MAX_ROWS_P) || (int'(wstat.col) >= MAX_COLS_P);

	assign blk_nxt = blk_q || (chk_s1 && (mem_rdata || oob_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			chk_s1  <= 1'b0;
			blk_q   <= 1'b0;
			vis_q   <= 1'b0;
			cerr_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			chk_s1  <= (state_q == ST_WALK);
			blk_q   <= (state_q == ST_DECODE) ? 1'b0 : blk_nxt;
			if (state_q == ST_DECODE) begin
				vis_q  <= 1'b0;
				cerr_q <= dec_err;
			end
			if (state_q == ST_DRAIN) vis_q <= !blk_nxt;
		end
	end

	always_ff @(posedge clk) begin
		oob_s1 <= oob;
	end

	assign done        = (state_q == ST_DONE);
	assign visible     = vis_q;
	assign coord_error = cerr_q;

	gls_walker u_walker (
		.clk   (clk),
		.ctrl  (wctrl),
		.row_a (row_a_q),
		.col_a (col_a_q),
		.row_b (row_b_q),
		.col_b (col_b_q),
		.stat  (wstat)
	);

	gls_grid_mem #(
		.AW (AW)
	) u_grid_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	`GLS_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")
	`GLS_ASSERT_NEXT(a_accept_decode, accept, state_q == ST_DECODE, "request not decoded")
	`GLS_ASSERT_IMP(a_err_not_vis, done && coord_error, !visible, "visible with coord error")
	`GLS_ASSERT_IMP(a_we_state, mem_we, (state_q == ST_CLEAR) || (state_q == ST_DECODE),
		"grid written outside clear or decode")
	`GLS_ASSERT_NEXT(a_walk_end, (state_q == ST_WALK) && wstat.last, state_q == ST_DRAIN,
		"walk did not end on last cell")

endmodule
